>>> design/gbc_pkg.sv
// Shared types and constants for the grid chase step block.
`timescale 1ns / 1ps
package gbc_pkg;

  localparam logic [1:0] OP_WALL  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_CHASE = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] OUT_STEPPED     = 2'd0;
  localparam logic [1:0] OUT_OFF_GRID    = 2'd1;
  localparam logic [1:0] OUT_UNREACHABLE = 2'd2;
  localparam logic [1:0] OUT_AT_TARGET   = 2'd3;

  localparam logic [0:0] CFG_WIDTH  = 1'd0;
  localparam logic [0:0] CFG_HEIGHT = 1'd1;

  localparam int unsigned DistW = 11;

  // One result item
  typedef struct packed {
    logic [1:0] agent_id;
    logic [4:0] new_x;
    logic [4:0] new_y;
    logic [1:0] outcome;
    logic       collided;
    logic       last;
  } gbc_result_t;

endpackage

>>> design/grid_bfs_chase_step.sv
// Grid chase step: wall map, breadth-first search and agent moves.
// Per item: a wall transaction writes the map, a place updates the agent registers. Chase: a
// clear sweep over every search store entry (1024 by default), then for each reached cell a
// queue read, center read and four neighbour read-modify-writes, then per agent a move that can stall on output.
// Throughput: one item at a time. Reset: a clearing pass of one cycle per store entry
// empties the wall map before the first item is accepted; registers reset to 30x20.
`timescale 1ns / 1ps
module grid_bfs_chase_step
  import gbc_pkg::*;
#(
  parameter int unsigned GRID_W = 32,
  parameter int unsigned GRID_H = 32,
  parameter int unsigned AGENTS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [4:0] cell_x_i,
  input  logic [4:0] cell_y_i,
  input  logic       is_wall_i,
  input  logic [1:0] agent_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] agent_id_o,
  output logic [4:0] new_x_o,
  output logic [4:0] new_y_o,
  output logic [1:0] outcome_o,
  output logic       collided_o,
  output logic       last_o
);

  // Coordinates are five bits wide, so no more than 32 columns or rows are addressed
  localparam int unsigned XW    = (GRID_W > 32) ? 5 : $clog2(GRID_W);
  localparam int unsigned YW    = (GRID_H > 32) ? 5 : $clog2(GRID_H);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned CELLS = 1 << AW;
  localparam int unsigned GW    = (AGENTS > 1) ? $clog2(AGENTS) : 1;
  localparam int unsigned QW    = AW + 1;
  // Search entry: reached, distance, occupied
  localparam int unsigned SW    = DistW + 2;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_WALL   = 5'd2;
  localparam logic [4:0] S_SCLR   = 5'd3;
  localparam logic [4:0] S_SEED   = 5'd4;
  localparam logic [4:0] S_QRD    = 5'd5;
  localparam logic [4:0] S_QWAIT  = 5'd6;
  localparam logic [4:0] S_NRD    = 5'd7;
  localparam logic [4:0] S_NWAIT  = 5'd8;
  localparam logic [4:0] S_NUPD   = 5'd9;
  localparam logic [4:0] S_OCC    = 5'd10;
  localparam logic [4:0] S_OCCW   = 5'd11;
  localparam logic [4:0] S_AGRD   = 5'd12;
  localparam logic [4:0] S_AGWT   = 5'd13;
  localparam logic [4:0] S_AGEVAL = 5'd14;
  localparam logic [4:0] S_MVRD   = 5'd15;
  localparam logic [4:0] S_MVWT   = 5'd16;
  localparam logic [4:0] S_MVCHK  = 5'd17;
  localparam logic [4:0] S_FREE   = 5'd18;
  localparam logic [4:0] S_TAKE   = 5'd19;
  localparam logic [4:0] S_EMIT   = 5'd20;
  localparam logic [4:0] S_CENTRD = 5'd21;
  localparam logic [4:0] S_CENTWT = 5'd22;

  logic [4:0] state_q, state_d;

  // Configuration registers
  logic [5:0] gw_q, gh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 6'd30;
      gh_q <= 6'd20;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) gw_q <= cfg_data_i;
      else gh_q <= cfg_data_i;
    end
  end

  // Effective grid size, clamped to the store
  logic [6:0] w_eff, h_eff;
  always_comb begin
    w_eff = {1'b0, gw_q};
    if (w_eff > 7'(GRID_W)) w_eff = 7'(GRID_W);
    if (w_eff > 7'd32) w_eff = 7'd32;
    h_eff = {1'b0, gh_q};
    if (h_eff > 7'(GRID_H)) h_eff = 7'(GRID_H);
    if (h_eff > 7'd32) h_eff = 7'd32;
  end

  // Agent positions
  logic [4:0] ax_q [AGENTS];
  logic [4:0] ay_q [AGENTS];

  // Work registers
  logic [4:0]   tx_q, ty_q, cx_q, cy_q, bx_q, by_q;
  logic [QW-1:0] head_q, tail_q, cnt_q;
  logic [1:0]   dir_q;
  logic [DistW-1:0] cdist_q;
  logic [GW:0]  ag_q;
  logic         wall_in_q;
  gbc_result_t  res_q;
  logic         out_valid_q;

  // Memories
  logic          wall_we, wall_rd;
  logic [AW-1:0] wall_addr;
  logic          srch_we;
  logic [AW-1:0] srch_addr;
  logic [SW-1:0] srch_wdata, srch_rd;
  logic          q_we;
  logic [AW-1:0] q_addr, q_wdata, q_rd;

  gbc_ram #(.Width(1), .Depth(CELLS), .AddrW(AW)) u_wall (
    .clk_i, .we_i(wall_we), .addr_i(wall_addr), .wdata_i(wall_in_q), .rdata_o(wall_rd)
  );
  gbc_ram #(.Width(SW), .Depth(CELLS), .AddrW(AW)) u_srch (
    .clk_i, .we_i(srch_we), .addr_i(srch_addr), .wdata_i(srch_wdata), .rdata_o(srch_rd)
  );
  gbc_ram #(.Width(AW), .Depth(CELLS), .AddrW(AW)) u_queue (
    .clk_i, .we_i(q_we), .addr_i(q_addr), .wdata_i(q_wdata), .rdata_o(q_rd)
  );

  logic             rd_reached, rd_occ;
  logic [DistW-1:0] rd_dist;
  assign rd_reached = srch_rd[SW-1];
  assign rd_dist    = srch_rd[SW-2 -: DistW];
  assign rd_occ     = srch_rd[0];

  function automatic logic [AW-1:0] cell_addr(logic [4:0] x, logic [4:0] y);
    logic [AW-1:0] a;
    a = {y[YW-1:0], x[XW-1:0]};
    return a;
  endfunction

  // Neighbour of the current cell in direction dir_q
  logic signed [6:0] nx, ny;
  logic              n_in;
  always_comb begin
    nx = $signed({2'b0, cx_q});
    ny = $signed({2'b0, cy_q});
    case (dir_q)
      2'd0:    nx = nx + 7'sd1;
      2'd1:    nx = nx - 7'sd1;
      2'd2:    ny = ny + 7'sd1;
      default: ny = ny - 7'sd1;
    endcase
    n_in = (nx >= 0) && (ny >= 0) && (nx < $signed(w_eff)) && (ny < $signed(h_eff));
  end

  logic [GW-1:0] ag_idx;
  assign ag_idx = ag_q[GW-1:0];

  logic [4:0] dxa, dya;
  assign dxa = (bx_q > tx_q) ? bx_q - tx_q : tx_q - bx_q;
  assign dya = (by_q > ty_q) ? by_q - ty_q : ty_q - by_q;

  logic in_fire, out_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Memory port control
  always_comb begin
    wall_we    = 1'b0;
    wall_addr  = cell_addr(cx_q, cy_q);
    srch_we    = 1'b0;
    srch_addr  = cell_addr(cx_q, cy_q);
    srch_wdata = '0;
    q_we       = 1'b0;
    q_addr     = head_q[AW-1:0];
    q_wdata    = cell_addr(nx[4:0], ny[4:0]);
    case (state_q)
      S_CLEAR: begin
        wall_we   = 1'b1;
        wall_addr = cnt_q[AW-1:0];
      end
      S_WALL: wall_we = 1'b1;
      S_SCLR: begin
        srch_we   = 1'b1;
        srch_addr = cnt_q[AW-1:0];
      end
      S_SEED: begin
        srch_we    = 1'b1;
        srch_addr  = cell_addr(tx_q, ty_q);
        srch_wdata = {1'b1, {DistW{1'b0}}, 1'b0};
        q_we       = 1'b1;
        q_addr     = '0;
        q_wdata    = cell_addr(tx_q, ty_q);
      end
      S_NRD, S_NWAIT: begin
        srch_addr = cell_addr(nx[4:0], ny[4:0]);
        wall_addr = cell_addr(nx[4:0], ny[4:0]);
      end
      S_NUPD: begin
        srch_addr  = cell_addr(nx[4:0], ny[4:0]);
        srch_wdata = {1'b1, cdist_q + 1'b1, rd_occ};
        srch_we    = n_in && !wall_rd && !rd_reached;
        q_addr     = tail_q[AW-1:0];
        q_we       = srch_we && (tail_q < QW'(CELLS));
      end
      S_OCC, S_AGRD, S_AGWT: srch_addr = cell_addr(ax_q[ag_idx], ay_q[ag_idx]);
      S_OCCW: begin
        srch_addr  = cell_addr(ax_q[ag_idx], ay_q[ag_idx]);
        srch_we    = 1'b1;
        srch_wdata = {srch_rd[SW-1:1], 1'b1};
      end
      S_MVRD, S_MVWT: srch_addr = cell_addr(nx[4:0], ny[4:0]);
      // Point at the cell that the take step updates
      S_MVCHK: begin
        if (n_in && rd_reached && rd_dist < cdist_q && !rd_occ)
          srch_addr = cell_addr(nx[4:0], ny[4:0]);
        else srch_addr = cell_addr(cx_q, cy_q);
      end
      S_CENTRD, S_CENTWT: srch_addr = cell_addr(cx_q, cy_q);
      S_FREE: begin
        srch_addr  = cell_addr(cx_q, cy_q);
        srch_we    = 1'b1;
        srch_wdata = {srch_rd[SW-1:1], 1'b0};
      end
      S_TAKE: begin
        srch_addr  = cell_addr(bx_q, by_q);
        srch_we    = 1'b1;
        srch_wdata = {srch_rd[SW-1:1], 1'b1};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      wall_in_q   <= 1'b0;
      for (int i = 0; i < AGENTS; i++) begin
        ax_q[i] <= '0;
        ay_q[i] <= '0;
      end
    end else begin
      if (out_fire) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == QW'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            cx_q <= cell_x_i;
            cy_q <= cell_y_i;
            tx_q <= cell_x_i;
            ty_q <= cell_y_i;
            wall_in_q <= is_wall_i;
            cnt_q <= '0;
            case (op_i)
              OP_WALL: begin
                if (32'(cell_x_i) < GRID_W && 32'(cell_y_i) < GRID_H) state_q <= S_WALL;
              end
              OP_PLACE: begin
                if (32'(agent_index_i) < AGENTS) begin
                  ax_q[GW'(agent_index_i)] <= cell_x_i;
                  ay_q[GW'(agent_index_i)] <= cell_y_i;
                end
              end
              OP_CHASE: state_q <= S_SCLR;
              default: ;
            endcase
          end
        end
        S_WALL: state_q <= S_IDLE;
        S_SCLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == QW'(CELLS - 1)) begin
            ag_q <= '0;
            if ({2'b0, tx_q} < w_eff && {2'b0, ty_q} < h_eff) state_q <= S_SEED;
            else state_q <= S_OCC;
          end
        end
        S_SEED: begin
          head_q  <= '0;
          tail_q  <= QW'(1);
          state_q <= S_QRD;
        end
        S_QRD: begin
          if (head_q == tail_q) begin
            ag_q    <= '0;
            state_q <= S_OCC;
          end else state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          // Queue data arrives now; load the cell, then read its center entry before the neighbours
          cx_q    <= q_rd[XW-1:0] + 5'd0;
          cy_q    <= 5'(q_rd[AW-1:XW]);
          head_q  <= head_q + 1'b1;
          dir_q   <= 2'd0;
          state_q <= S_CENTRD;
        end
        S_CENTRD: state_q <= S_CENTWT;
        S_CENTWT: begin
          cdist_q <= rd_dist;
          state_q <= S_NRD;
        end
        S_NRD: state_q <= n_in ? S_NWAIT : S_NUPD;
        S_NWAIT: state_q <= S_NUPD;
        S_NUPD: begin
          if (n_in && srch_we && q_we) tail_q <= tail_q + 1'b1;
          dir_q <= dir_q + 1'b1;
          state_q <= (dir_q == 2'd3) ? S_QRD : S_NRD;
        end
        S_OCC: begin
          if (ag_q == (GW+1)'(AGENTS)) begin
            ag_q    <= '0;
            state_q <= S_AGRD;
          end else if ({2'b0, ax_q[ag_idx]} < w_eff && {2'b0, ay_q[ag_idx]} < h_eff)
            state_q <= S_OCCW;
          else ag_q <= ag_q + 1'b1;
        end
        S_OCCW: begin
          ag_q    <= ag_q + 1'b1;
          state_q <= S_OCC;
        end
        S_AGRD: begin
          if (ag_q == (GW+1)'(AGENTS)) state_q <= S_IDLE;
          else if (!out_valid_q || out_fire) begin
            cx_q <= ax_q[ag_idx];
            cy_q <= ay_q[ag_idx];
            bx_q <= ax_q[ag_idx];
            by_q <= ay_q[ag_idx];
            state_q <= S_AGWT;
          end
        end
        S_AGWT: state_q <= S_AGEVAL;
        S_AGEVAL: begin
          res_q.agent_id <= 2'(ag_idx);
          res_q.new_x    <= cx_q;
          res_q.new_y    <= cy_q;
          res_q.collided <= 1'b0;
          res_q.last     <= (ag_q == (GW+1)'(AGENTS - 1));
          dir_q   <= 2'd0;
          cdist_q <= rd_dist;
          if (!({2'b0, cx_q} < w_eff && {2'b0, cy_q} < h_eff)) begin
            res_q.outcome <= OUT_OFF_GRID;
            state_q <= S_EMIT;
          end else if (!rd_reached) begin
            res_q.outcome <= OUT_UNREACHABLE;
            state_q <= S_EMIT;
          end else if (rd_dist == '0) begin
            res_q.outcome <= OUT_AT_TARGET;
            state_q <= S_EMIT;
          end else begin
            res_q.outcome <= OUT_STEPPED;
            state_q <= S_FREE;
          end
        end
        S_FREE: state_q <= S_MVRD;
        S_MVRD: state_q <= n_in ? S_MVWT : S_MVCHK;
        S_MVWT: state_q <= S_MVCHK;
        S_MVCHK: begin
          if (n_in && rd_reached && rd_dist < cdist_q && !rd_occ) begin
            bx_q    <= nx[4:0];
            by_q    <= ny[4:0];
            state_q <= S_TAKE;
          end else if (dir_q == 2'd3) state_q <= S_TAKE;
          else begin
            dir_q   <= dir_q + 1'b1;
            state_q <= S_MVRD;
          end
        end
        S_TAKE: begin
          ax_q[ag_idx] <= bx_q;
          ay_q[ag_idx] <= by_q;
          res_q.new_x  <= bx_q;
          res_q.new_y  <= by_q;
          if (dxa <= 5'd1 && dya <= 5'd1) begin
            res_q.collided <= 1'b1;
            res_q.last     <= 1'b1;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_q <= 1'b1;
          ag_q        <= res_q.last ? (GW+1)'(AGENTS) : ag_q + 1'b1;
          state_q     <= S_AGRD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign agent_id_o  = res_q.agent_id;
  assign new_x_o     = res_q.new_x;
  assign new_y_o     = res_q.new_y;
  assign outcome_o   = res_q.outcome;
  assign collided_o  = res_q.collided;
  assign last_o      = res_q.last;

  // A collision always closes the step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && collided_o |-> last_o) else $error("collision not last");
  // Only stepped agents collide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && collided_o |-> outcome_o == OUT_STEPPED) else $error("bad collide");
  // No input taken while a search is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NUPD |-> !in_ready_o) else $error("ready during search");
  // Queue head never passes tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_QWAIT |-> head_q < tail_q) else $error("queue underrun");

endmodule

>>> design/gbc_ram.sv
// Single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gbc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write when enabled; the read data is registered and shows the old contents during a write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the grid chase step block.
`timescale 1ns / 1ps
module testbench;
  import gbc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 20000000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned SETTLE       = 40;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] x;
    logic [4:0] y;
    logic       wall;
    logic [1:0] agent;
  } chase_cmd_t;

  // Predicts agent moves and keeps the pending results in order
  class chase_scoreboard;
    bit          wall_bits[1024];
    logic [4:0]  pos_x[4];
    logic [4:0]  pos_y[4];
    int unsigned width_reg;
    int unsigned height_reg;
    gbc_result_t pending_q[$];
    int          mismatches;
    int          results_seen;
    int          collisions;
    int          chases;

    function new();
      foreach (wall_bits[i]) wall_bits[i] = 1'b0;
      foreach (pos_x[i]) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
      end
      width_reg  = 30;
      height_reg = 20;
    endfunction

    function void set_reg(logic idx, logic [5:0] val);
      if (idx == CFG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // Work out the results of one accepted transaction
    function void note_input(chase_cmd_t t);
      int          dx[4] = '{1, -1, 0, 0};
      int          dy[4] = '{0, 0, 1, -1};
      bit          reached[1024];
      bit          occ[1024];
      int          dist_map[1024];
      int          fifo[$];
      int          gw, gh, here, nb, nx, ny, c, bx, by, ddx, ddy;
      gbc_result_t r;
      case (t.op)
        OP_WALL:  wall_bits[{t.y, t.x}] = t.wall;
        OP_PLACE: begin
          pos_x[t.agent] = t.x;
          pos_y[t.agent] = t.y;
        end
        OP_CHASE: begin
          chases++;
          gw = (width_reg > 32) ? 32 : width_reg;
          gh = (height_reg > 32) ? 32 : height_reg;
          foreach (reached[i]) begin
            reached[i]  = 1'b0;
            occ[i]      = 1'b0;
            dist_map[i] = 0;
          end
          // Breadth-first search out from the target
          if (t.x < gw && t.y < gh) begin
            here = t.y * 32 + t.x;
            reached[here] = 1'b1;
            fifo.push_back(here);
            while (fifo.size() > 0) begin
              c = fifo.pop_front();
              for (int d = 0; d < 4; d++) begin
                nx = c % 32 + dx[d];
                ny = c / 32 + dy[d];
                if (nx < 0 || ny < 0 || nx >= gw || ny >= gh) continue;
                nb = ny * 32 + nx;
                if (wall_bits[nb] || reached[nb]) continue;
                reached[nb] = 1'b1;
                dist_map[nb] = (dist_map[c] + 1) & 'h7FF;
                fifo.push_back(nb);
              end
            end
          end
          for (int g = 0; g < 4; g++)
            if (pos_x[g] < gw && pos_y[g] < gh) occ[pos_y[g] * 32 + pos_x[g]] = 1'b1;
          // Move agents in index order
          for (int g = 0; g < 4; g++) begin
            r = '0;
            r.agent_id = 2'(g);
            if (pos_x[g] >= gw || pos_y[g] >= gh) begin
              r.outcome = OUT_OFF_GRID;
            end else begin
              here = pos_y[g] * 32 + pos_x[g];
              if (!reached[here]) r.outcome = OUT_UNREACHABLE;
              else if (dist_map[here] == 0) r.outcome = OUT_AT_TARGET;
              else begin
                r.outcome = OUT_STEPPED;
                bx = pos_x[g];
                by = pos_y[g];
                occ[here] = 1'b0;
                for (int d = 0; d < 4; d++) begin
                  nx = pos_x[g] + dx[d];
                  ny = pos_y[g] + dy[d];
                  if (nx < 0 || ny < 0 || nx >= gw || ny >= gh) continue;
                  c = ny * 32 + nx;
                  if (reached[c] && dist_map[c] < dist_map[here] && !occ[c]) begin
                    bx = nx;
                    by = ny;
                    break;
                  end
                end
                occ[by * 32 + bx] = 1'b1;
                pos_x[g] = 5'(bx);
                pos_y[g] = 5'(by);
                ddx = (bx > t.x) ? bx - t.x : t.x - bx;
                ddy = (by > t.y) ? by - t.y : t.y - by;
                r.collided = (ddx <= 1 && ddy <= 1);
              end
            end
            r.new_x = pos_x[g];
            r.new_y = pos_y[g];
            r.last  = r.collided || g == 3;
            pending_q.push_back(r);
            if (r.collided) begin
              collisions++;
              break;
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one delivered result with the oldest expectation
    function void check(gbc_result_t got);
      gbc_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.agent_id !== want.agent_id || got.new_x !== want.new_x ||
          got.new_y !== want.new_y || got.outcome !== want.outcome ||
          got.collided !== want.collided || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i, cfg_index_i;
  logic [5:0] cfg_data_i;
  logic       in_valid_i, in_ready_o;
  logic [1:0] op_i;
  logic [4:0] cell_x_i, cell_y_i;
  logic       is_wall_i;
  logic [1:0] agent_index_i;
  logic       out_valid_o, out_ready_i;
  logic [1:0] agent_id_o;
  logic [4:0] new_x_o, new_y_o;
  logic [1:0] outcome_o;
  logic       collided_o, last_o;

  chase_scoreboard sb = new();
  int unsigned     cycles;
  int unsigned     items_sent;
  bit              hold_out;
  bit              no_gaps;

  grid_bfs_chase_step dut (.*);

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[grid_bfs_chase_step] ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receive results with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check('{agent_id_o, new_x_o, new_y_o, outcome_o, collided_o, last_o});
      if (stall > 0) stall--;
      else stall = pick_gap();
      out_ready_i <= !hold_out && stall == 0;
    end
  end

  initial begin
    hold_out = 1'b0;
    wait (sb.results_seen >= 30);
    @(posedge clk_i);
    hold_out = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_out = 1'b0;
  end

  // Offer one transaction and hold it until it is accepted
  task automatic send(chase_cmd_t t);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    op_i          <= t.op;
    cell_x_i      <= t.x;
    cell_y_i      <= t.y;
    is_wall_i     <= t.wall;
    agent_index_i <= t.agent;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(t);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [5:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [4:0] pick_coord(int unsigned span);
    int unsigned lim;
    lim = (span > 32) ? 32 : span;
    if (lim == 0 || $urandom_range(0, 9) < 2) return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, lim - 1));
  endfunction

  // Mostly in-grid walls, placements and chases with some noise
  task automatic random_phase(int unsigned count);
    chase_cmd_t  t;
    int unsigned roll;
    for (int i = 0; i < count; i++) begin
      roll   = $urandom_range(0, 99);
      t.op   = (roll < 42) ? OP_WALL : (roll < 66) ? OP_PLACE : (roll < 95) ? OP_CHASE : OP_RSVD;
      t.x    = pick_coord(sb.width_reg);
      t.y    = pick_coord(sb.height_reg);
      t.wall = $urandom_range(0, 9) < 3;
      t.agent = 2'($urandom_range(0, 3));
      send(t);
    end
  endtask

  initial begin
    chase_cmd_t  directed[$];
    logic [5:0]  widths[6]  = '{6'd8, 6'd32, 6'd1, 6'd0, 6'd63, 6'd5};
    logic [5:0]  heights[6] = '{6'd6, 6'd32, 6'd1, 6'd7, 6'd63, 6'd0};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OP_WALL;
    cell_x_i = '0;
    cell_y_i = '0;
    is_wall_i = 1'b0;
    agent_index_i = '0;
    items_sent = 0;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: walls, boxed-in agent, off-grid agent, target cases, collision
    directed = '{
      '{OP_WALL, 5'd0, 5'd0, 1'b1, 2'd0},   '{OP_WALL, 5'd31, 5'd31, 1'b1, 2'd3},
      '{OP_WALL, 5'd5, 5'd5, 1'b0, 2'd0},   '{OP_WALL, 5'd9, 5'd10, 1'b1, 2'd0},
      '{OP_WALL, 5'd11, 5'd10, 1'b1, 2'd0}, '{OP_WALL, 5'd10, 5'd9, 1'b1, 2'd0},
      '{OP_WALL, 5'd10, 5'd11, 1'b1, 2'd0}, '{OP_PLACE, 5'd3, 5'd3, 1'b0, 2'd0},
      '{OP_PLACE, 5'd31, 5'd31, 1'b1, 2'd1}, '{OP_PLACE, 5'd10, 5'd10, 1'b0, 2'd2},
      '{OP_PLACE, 5'd6, 5'd5, 1'b0, 2'd3},  '{OP_CHASE, 5'd6, 5'd5, 1'b0, 2'd0},
      '{OP_CHASE, 5'd25, 5'd25, 1'b0, 2'd0}, '{OP_CHASE, 5'd0, 5'd0, 1'b0, 2'd0},
      '{OP_RSVD, 5'd31, 5'd31, 1'b1, 2'd3}, '{OP_PLACE, 5'd5, 5'd5, 1'b0, 2'd0},
      '{OP_CHASE, 5'd6, 5'd6, 1'b0, 2'd0},  '{OP_PLACE, 5'd2, 5'd2, 1'b0, 2'd2},
      '{OP_PLACE, 5'd2, 5'd2, 1'b0, 2'd3},  '{OP_CHASE, 5'd2, 5'd8, 1'b0, 2'd0},
      '{OP_CHASE, 5'd29, 5'd19, 1'b0, 2'd0}
    };
    foreach (directed[i]) send(directed[i]);
    random_phase(15);

    // Sweep grid sizes, extremes included
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(CFG_WIDTH, widths[p]);
      write_reg(CFG_HEIGHT, heights[p]);
      no_gaps = (p == 2);
      random_phase(17);
    end

    drain();
    if (sb.pending() != 0) sb.mismatches++;
    $display("%0d transactions sent, %0d chase steps, %0d results checked, %0d collisions",
             items_sent, sb.chases, sb.results_seen, sb.collisions);
    $display("grid sizes from 0 to 63 per side, %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[grid_bfs_chase_step] OK");
    end else begin
      $display("[grid_bfs_chase_step] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gbc_pkg.sv
design/gbc_ram.sv
design/grid_bfs_chase_step.sv
tb/testbench.sv
